>>> rtl/p2c_pkg.sv
package p2c_pkg;

   // Default number of plane cells the block is built with.
   localparam int MAX_PLANES_DEFAULT = 8;

   // Depth mode codes.
   localparam logic [2:0] MODE_MONO   = 3'd0;
   localparam logic [2:0] MODE_P2     = 3'd1;
   localparam logic [2:0] MODE_P4     = 3'd2;
   localparam logic [2:0] MODE_P8     = 3'd3;
   localparam logic [2:0] MODE_RGB565 = 3'd4;
   localparam logic [2:0] MODE_TRUE24 = 3'd5;

   // Register indexes on the configuration channel.
   localparam logic [1:0] REG_DEPTH_MODE  = 2'd0;
   localparam logic [1:0] REG_INVERT_MONO = 2'd1;

   // Results per completed group, by mode.
   localparam logic [4:0] CNT_MONO   = 5'd8;
   localparam logic [4:0] CNT_PLANAR = 5'd16;
   localparam logic [4:0] CNT_RGB565 = 5'd3;
   localparam logic [4:0] CNT_TRUE24 = 5'd1;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;
   typedef logic [2:0]  mode_type;
   typedef logic [1:0]  csr_index_type;
   typedef logic [2:0]  csr_data_type;

endpackage

>>> rtl/p2c_if.sv
interface p2c_req_if;
   logic               valid;
   logic               ready;
   p2c_pkg::byte_type  data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface p2c_rsp_if;
   logic               valid;
   logic               ready;
   p2c_pkg::byte_type  pixel_value;
   logic               last_of_run;

   modport source (output valid, output pixel_value, output last_of_run, input ready);
   modport sink   (input valid, input pixel_value, input last_of_run, output ready);
endinterface

interface p2c_csr_if;
   logic                   valid;
   logic                   ready;
   p2c_pkg::csr_index_type index;
   p2c_pkg::csr_data_type  wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> rtl/p2c_cell.sv
module p2c_cell (
   input  logic              clock,
   input  p2c_pkg::byte_type chain_in,
   input  logic              col_shift,
   input  logic              load,
   input  p2c_pkg::word_type load_word,
   input  logic              out_shift,
   output p2c_pkg::word_type col_word,
   output p2c_pkg::word_type out_word
);
   import p2c_pkg::*;

   word_type col_ff;
   word_type out_ff;

   // The collection word moves one byte toward the far end of the chain per beat.
   always_ff @(posedge clock) begin
      if (col_shift) begin
         col_ff <= {col_ff[7:0], chain_in};
      end
      if (load) begin
         out_ff <= load_word;
      end else if (out_shift) begin
         out_ff <= {out_ff[14:0], 1'b0};
      end
   end

   assign col_word = col_ff;
   assign out_word = out_ff;

endmodule

>>> rtl/planar_to_chunky_pixel_unpacker.sv
// Channel   Direction  Payload                        Handshake
// req_chan  in         data_byte[7:0]                 valid / ready
// rsp_chan  out        pixel_value[7:0], last_of_run  valid / ready
// csr_chan  in         index[1:0], wdata[2:0]         valid / ready (always ready)
//
// The result port moves one beat per cycle while rsp_chan.valid and rsp_chan.ready are
// high, and that port sets the rate: a 1-plane byte gives 8 results, a planar group of
// 2*P bytes gives 16, an RGB565 word gives 3 and a 24-bit byte gives 1.
// Reset clears the mode, the byte position and the handshake state; the plane cells
// hold payload only and need no reset. A stalled result port holds the current beat,
// and the input keeps filling the collection words until one complete group waits.
module planar_to_chunky_pixel_unpacker #(
   parameter int MAX_PLANES = p2c_pkg::MAX_PLANES_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   p2c_req_if.sink   req_chan,
   p2c_rsp_if.source rsp_chan,
   p2c_csr_if.sink   csr_chan
);
   import p2c_pkg::*;

   // Each cell holds one plane word. During collection the bytes ripple through the
   // chain, so after a full group the newest plane sits in cell 0 and plane 0 sits in
   // cell P-1. The output words are loaded in plane order and shift out MSB first.

   localparam logic [3:0] MaxPlanes = 4'(MAX_PLANES);

   mode_type   depth_mode_ff, depth_mode_in;
   logic       invert_mono_ff, invert_mono_in;
   logic [3:0] pos_ff, pos_in;
   logic       pend_ff, pend_in;
   logic [4:0] cnt_ff, cnt_in;
   mode_type   kind_ff, kind_in;

   logic       req_beat;
   logic       rsp_beat;
   logic       csr_beat;
   logic       xfer;
   logic       group_done;
   logic       out_shift;
   logic [3:0] plane_req;
   logic [3:0] planes;
   logic [4:0] need;
   logic [4:0] load_cnt;

   word_type   col_word  [MAX_PLANES];
   word_type   out_word  [MAX_PLANES];
   word_type   load_word [MAX_PLANES];
   logic [MAX_PLANES-1:0] msb_vec;

   assign csr_beat = csr_chan.valid && csr_chan.ready;
   assign rsp_beat = rsp_chan.valid && rsp_chan.ready;
   assign req_beat = req_chan.valid && req_chan.ready;

   // A waiting group moves into the output words once the last beat is leaving or none remains.
   assign xfer = pend_ff && ((cnt_ff == 5'd0) || (rsp_beat && (cnt_ff == 5'd1)));

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = !pend_ff || xfer;

   // Plane count for the planar modes, held to the number of cells built.
   always_comb begin
      case (depth_mode_ff)
         MODE_P2: plane_req = 4'd2;
         MODE_P4: plane_req = 4'd4;
         MODE_P8: plane_req = 4'd8;
         default: plane_req = 4'd1;
      endcase
      planes = (plane_req > MaxPlanes) ? MaxPlanes : plane_req;
      need   = (depth_mode_ff == MODE_RGB565) ? 5'd2 : {planes, 1'b0};
   end

   // Collection position and group completion.
   always_comb begin
      pos_in     = pos_ff;
      group_done = 1'b0;
      if (req_beat) begin
         case (depth_mode_ff)
            MODE_MONO, MODE_TRUE24: begin
               group_done = 1'b1;
            end
            MODE_P2, MODE_P4, MODE_P8, MODE_RGB565: begin
               if ((5'(pos_ff) + 5'd1) >= need) begin
                  group_done = 1'b1;
                  pos_in     = 4'd0;
               end else begin
                  pos_in = pos_ff + 4'd1;
               end
            end
            default: begin
               group_done = 1'b0;
            end
         endcase
      end
      if (csr_beat && (csr_chan.index == REG_DEPTH_MODE)) begin
         pos_in = 4'd0;
      end
   end

   // Configuration registers; they are to be written only while the block is idle (the block does not enforce this).
   always_comb begin
      depth_mode_in  = depth_mode_ff;
      invert_mono_in = invert_mono_ff;
      if (csr_beat) begin
         case (csr_chan.index)
            REG_DEPTH_MODE:  depth_mode_in  = csr_chan.wdata;
            REG_INVERT_MONO: invert_mono_in = csr_chan.wdata[0];
            default:         depth_mode_in  = depth_mode_ff;
         endcase
      end
   end

   always_comb begin
      case (depth_mode_ff)
         MODE_MONO:   load_cnt = CNT_MONO;
         MODE_RGB565: load_cnt = CNT_RGB565;
         MODE_TRUE24: load_cnt = CNT_TRUE24;
         default:     load_cnt = CNT_PLANAR;
      endcase
   end

   // Pending flag and output beat counter.
   always_comb begin
      pend_in = pend_ff;
      if (xfer) begin
         pend_in = 1'b0;
      end
      if (group_done) begin
         pend_in = 1'b1;
      end
      cnt_in  = cnt_ff;
      kind_in = kind_ff;
      if (xfer) begin
         cnt_in  = load_cnt;
         kind_in = depth_mode_ff;
      end else if (rsp_beat) begin
         cnt_in = cnt_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_mode_ff  <= MODE_MONO;
         invert_mono_ff <= 1'b0;
         pos_ff         <= 4'd0;
         pend_ff        <= 1'b0;
         cnt_ff         <= 5'd0;
         kind_ff        <= MODE_MONO;
      end else begin
         depth_mode_ff  <= depth_mode_in;
         invert_mono_ff <= invert_mono_in;
         pos_ff         <= pos_in;
         pend_ff        <= pend_in;
         cnt_ff         <= cnt_in;
         kind_ff        <= kind_in;
      end
   end

   // Only the bit-per-pixel layouts walk through the output words.
   assign out_shift = rsp_beat && ((kind_ff == MODE_MONO) || (kind_ff == MODE_P2) ||
                                   (kind_ff == MODE_P4) || (kind_ff == MODE_P8));

   for (genvar j = 0; j < MAX_PLANES; j++) begin : g_cell
      byte_type chain_in;

      if (j == 0) begin : g_head
         assign chain_in = req_chan.data_byte;
      end else begin : g_link
         assign chain_in = col_word[j-1][15:8];
      end

      // Output cell j takes plane j, which the collection chain holds in cell P-1-j.
      // Cells above the plane count load zero, so the pixel needs no masking.
      always_comb begin
         load_word[j] = '0;
         case (depth_mode_ff)
            MODE_MONO: begin
               if (j == 0) begin
                  load_word[j] = {col_word[0][7:0] ^ {8{invert_mono_ff}}, 8'h00};
               end
            end
            MODE_P2, MODE_P4, MODE_P8: begin
               for (int i = 0; i < MAX_PLANES; i++) begin
                  if ((j < int'(planes)) && (i == int'(planes) - 1 - j)) begin
                     load_word[j] = col_word[i];
                  end
               end
            end
            MODE_RGB565, MODE_TRUE24: begin
               if (j == 0) begin
                  load_word[j] = col_word[0];
               end
            end
            default: begin
               load_word[j] = '0;
            end
         endcase
      end

      p2c_cell u_cell (
         .clock     (clock),
         .chain_in  (chain_in),
         .col_shift (req_beat),
         .load      (xfer),
         .load_word (load_word[j]),
         .out_shift (out_shift),
         .col_word  (col_word[j]),
         .out_word  (out_word[j])
      );

      assign msb_vec[j] = out_word[j][15];
   end

   // Result formatting by the layout of the group now being sent.
   always_comb begin
      case (kind_ff)
         MODE_RGB565: begin
            if (cnt_ff == CNT_RGB565) begin
               rsp_chan.pixel_value = {out_word[0][15:11], 3'b000};
            end else if (cnt_ff == 5'd2) begin
               rsp_chan.pixel_value = {out_word[0][10:5], 2'b00};
            end else begin
               rsp_chan.pixel_value = {out_word[0][4:0], 3'b000};
            end
         end
         MODE_TRUE24: begin
            rsp_chan.pixel_value = out_word[0][7:0];
         end
         default: begin
            rsp_chan.pixel_value = 8'(msb_vec);
         end
      endcase
   end

   assign rsp_chan.valid       = (cnt_ff != 5'd0);
   assign rsp_chan.last_of_run = (cnt_ff == 5'd1);

endmodule
